@@ hw/rtl/sch_pkg.sv @@
`timescale 1ns / 1ps

package sch_pkg;

	// item kinds
	localparam logic [1:0] KIND_SPIKE    = 2'd0;
	localparam logic [1:0] KIND_FINALIZE = 2'd1;
	localparam logic [1:0] KIND_READ     = 2'd2;
	localparam logic [1:0] KIND_CLEAR    = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_GROUP = 3'd1;
	localparam logic [2:0] ST_BAD_BIN   = 3'd2;
	localparam logic [2:0] ST_FINALIZED = 3'd3;
	localparam logic [2:0] ST_BAD_READ  = 3'd4;

	// configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRP_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_INTERVAL = 2'd2;

	localparam logic [10:0] NUM_BINS_RST     = 11'd1024;
	localparam logic [4:0]  GRP_LIMIT_RST    = 5'd16;
	localparam logic [31:0] BIN_INTERVAL_RST = 32'd65536;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  group;
		logic [31:0] stamp;
		logic [9:0]  bin;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] count_value;
	} out_item_t;

endpackage

@@ hw/rtl/sch_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, QW bits.
// Caller guarantees dividend < divisor << QW.
module sch_div #(
	parameter int QW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [31:0]   divisor,
	output logic          done,
	output logic [QW-1:0] quotient
);

	localparam int DW = 32 + QW;
	localparam int CW = $clog2(QW + 1);

	logic [31:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic          ge;

	assign ge = DW'(rem_q) >= den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			den_q <= DW'(divisor) << (QW - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q[31:0];
			end
			den_q <= den_q >> 1;
			quo_q <= (quo_q << 1) | QW'(ge);
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hw/rtl/sch_mem.sv @@
`timescale 1ns / 1ps

// Count table: one write port, one read port, registered read data.
module sch_mem #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14,
	parameter int CW    = 32
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [CW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [CW-1:0] wr_data
);

	logic [CW-1:0] mem [DEPTH];
	logic [CW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

@@ hw/rtl/spike_count_histogram_cumsum.sv @@
// Spike count histogram with per-group running sum. Each input item is a
// spike, a finalize, a read or a clear, and each gives exactly one result
// item (status and count). Counts live in one MAX_GROUPS x MAX_BINS table
// in a synchronous memory, group-major, saturating at 2^COUNT_WIDTH - 1.
// Items are handled one at a time. A spike goes through a range check
// (time against num_bins * bin_interval), the bit-serial divider that
// forms the bin, QW = log2(MAX_BINS) bits wide, then a read and a write of
// the table entry. A read returns one table entry. A finalize streams the
// entries in use once, one entry per cycle through the memory's read and
// write ports. A clear, and the clearing pass after reset, zero the memory
// one entry per cycle, during which no item is accepted; configuration
// writes are taken at any time. A finished result waits in an output
// register, so the next item is accepted while it is still unread.
`timescale 1ns / 1ps

module spike_count_histogram_cumsum #(
	parameter int MAX_BINS    = 1024,
	parameter int MAX_GROUPS  = 16,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  sch_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output sch_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [sch_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sch_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int DEPTH = MAX_BINS * MAX_GROUPS;
	localparam int AW    = $clog2(DEPTH);
	localparam int QW    = $clog2(MAX_BINS);
	localparam int BW    = QW;
	localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int NBW   = $clog2(MAX_BINS + 1);
	localparam int NGW   = $clog2(MAX_GROUPS + 1);
	localparam int PW    = 32 + NBW;
	localparam int CW    = COUNT_WIDTH;

	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_SRD    = 4'd4;
	localparam logic [3:0] S_SWR    = 4'd5;
	localparam logic [3:0] S_RRD    = 4'd6;
	localparam logic [3:0] S_RDAT   = 4'd7;
	localparam logic [3:0] S_FIN    = 4'd8;
	localparam logic [3:0] S_FDRAIN = 4'd9;
	localparam logic [3:0] S_OUT    = 4'd10;

	// config registers
	logic [10:0] num_bins_q;
	logic [4:0]  grp_limit_q;
	logic [31:0] bin_interval_q;

	// control
	logic [3:0]    state_q;
	logic          finalized_q;
	logic          clr_reply_q;
	logic [AW-1:0] clr_addr_q;
	logic [BW-1:0] fb_q;
	logic [GW-1:0] fg_q;
	logic [AW-1:0] base_q;
	logic          fin_v_s1;
	logic          out_valid_q;

	// payload
	logic [1:0]    kind_q;
	logic [7:0]    grp_q;
	logic [31:0]   time_q;
	logic [9:0]    rbin_q;
	logic [PW-1:0] prod_q;
	logic [2:0]    res_status_q;
	logic [31:0]   res_value_q;
	logic [CW-1:0] run_q;
	logic          fin_first_s1;
	logic [AW-1:0] fin_addr_s1;
	sch_pkg::out_item_t out_q;

	// derived
	logic [31:0]   nb32;
	logic [31:0]   ng32;
	logic [NBW-1:0] eff_nb;
	logic [NGW-1:0] eff_ng;
	logic          in_grp_bad;
	logic          in_read_bad;
	logic          accept;
	logic          out_free;
	logic          div_start;
	logic          div_done;
	logic [QW-1:0] quotient;
	logic [31:0]   bsel32;
	logic [31:0]   addr32;
	logic [AW-1:0] item_addr;
	logic [AW-1:0] fin_rd_addr;
	logic          fin_last_bin;
	logic          fin_last_grp;
	logic          mem_rd_en;
	logic [AW-1:0] mem_rd_addr;
	logic [CW-1:0] mem_rd_data;
	logic          mem_wr_en;
	logic [AW-1:0] mem_wr_addr;
	logic [CW-1:0] mem_wr_data;
	logic [CW:0]   inc_sum;
	logic [CW-1:0] inc_val;
	logic [CW:0]   acc_sum;
	logic [CW-1:0] fin_val;
	logic [63:0]   rd_wide;

	// registers above the table size act as the table size
	assign nb32 = (32'(num_bins_q) > 32'(MAX_BINS)) ? 32'(MAX_BINS) : 32'(num_bins_q);
	assign ng32 = (32'(grp_limit_q) > 32'(MAX_GROUPS)) ?
		32'(MAX_GROUPS) : 32'(grp_limit_q);
	assign eff_nb = nb32[NBW-1:0];
	assign eff_ng = ng32[NGW-1:0];

	assign in_grp_bad  = (in_data.group == 8'd0) || (32'(in_data.group) > 32'(eff_ng));
	assign in_read_bad = in_grp_bad || (32'(in_data.bin) >= 32'(eff_nb));

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// group-major slot: (group - 1) * MAX_BINS + bin
	assign bsel32    = (kind_q == sch_pkg::KIND_SPIKE) ? 32'(quotient) : 32'(rbin_q);
	assign addr32    = 32'(8'(grp_q - 8'd1)) * 32'(MAX_BINS) + bsel32;
	assign item_addr = addr32[AW-1:0];

	assign fin_rd_addr  = base_q + AW'(fb_q);
	assign fin_last_bin = (32'(fb_q) + 32'd1) == 32'(eff_nb);
	assign fin_last_grp = (32'(fg_q) + 32'd1) == 32'(eff_ng);

	// saturating adders
	assign inc_sum = {1'b0, mem_rd_data} + (CW + 1)'(1);
	assign inc_val = inc_sum[CW] ? {CW{1'b1}} : inc_sum[CW-1:0];
	assign acc_sum = {1'b0, mem_rd_data} + {1'b0, run_q};
	assign fin_val = fin_first_s1 ? mem_rd_data :
		(acc_sum[CW] ? {CW{1'b1}} : acc_sum[CW-1:0]);

	assign rd_wide   = 64'(mem_rd_data);
	assign div_start = (state_q == S_CHK) && (PW'(time_q) < prod_q);

	// table port muxing; only one item in flight, so a spike's write lands
	// before any later read of the same entry
	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = item_addr;
		mem_wr_en   = 1'b0;
		mem_wr_addr = item_addr;
		mem_wr_data = inc_val;
		if (state_q == S_SRD || state_q == S_RRD) begin
			mem_rd_en = 1'b1;
		end else if (state_q == S_FIN) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = fin_rd_addr;
		end
		if (state_q == S_CLEAR) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = clr_addr_q;
			mem_wr_data = '0;
		end else if (state_q == S_SWR) begin
			mem_wr_en = 1'b1;
		end else if (fin_v_s1) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = fin_addr_s1;
			mem_wr_data = fin_val;
		end
	end

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bins_q     <= sch_pkg::NUM_BINS_RST;
			grp_limit_q    <= sch_pkg::GRP_LIMIT_RST;
			bin_interval_q <= sch_pkg::BIN_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sch_pkg::REG_NUM_BINS:     num_bins_q     <= cfg_data[10:0];
				sch_pkg::REG_GRP_LIMIT:    grp_limit_q    <= cfg_data[4:0];
				sch_pkg::REG_BIN_INTERVAL: bin_interval_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			finalized_q <= 1'b0;
			clr_reply_q <= 1'b0;
			clr_addr_q  <= '0;
			fb_q        <= '0;
			fg_q        <= '0;
			base_q      <= '0;
			fin_v_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fin_v_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (32'(clr_addr_q) == 32'(DEPTH - 1)) begin
						clr_addr_q <= '0;
						state_q    <= clr_reply_q ? S_OUT : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (in_data.kind)
							sch_pkg::KIND_SPIKE: begin
								if (finalized_q || in_grp_bad) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_CHK;
								end
							end
							sch_pkg::KIND_FINALIZE: begin
								fb_q   <= '0;
								fg_q   <= '0;
								base_q <= '0;
								if (finalized_q || eff_nb == '0 || eff_ng == '0) begin
									finalized_q <= 1'b1;
									state_q     <= S_OUT;
								end else begin
									state_q <= S_FIN;
								end
							end
							sch_pkg::KIND_READ: begin
								state_q <= in_read_bad ? S_OUT : S_RRD;
							end
							default: begin
								finalized_q <= 1'b0;
								clr_reply_q <= 1'b1;
								clr_addr_q  <= '0;
								state_q     <= S_CLEAR;
							end
						endcase
					end
				end
				S_CHK: begin
					state_q <= div_start ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SRD;
					end
				end
				S_SRD:  state_q <= S_SWR;
				S_SWR:  state_q <= S_OUT;
				S_RRD:  state_q <= S_RDAT;
				S_RDAT: state_q <= S_OUT;
				S_FIN: begin
					fin_v_s1 <= 1'b1;
					fb_q     <= fb_q + BW'(1);
					if (fin_last_bin) begin
						fb_q   <= '0;
						base_q <= base_q + AW'(MAX_BINS);
						fg_q   <= fg_q + GW'(1);
						if (fin_last_grp) begin
							state_q <= S_FDRAIN;
						end
					end
				end
				S_FDRAIN: begin
					finalized_q <= 1'b1;
					state_q     <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						clr_reply_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and result
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q       <= in_data.kind;
			grp_q        <= in_data.group;
			time_q       <= in_data.stamp;
			rbin_q       <= in_data.bin;
			prod_q       <= PW'(eff_nb) * PW'(bin_interval_q);
			res_value_q  <= '0;
			res_status_q <= sch_pkg::ST_OK;
			case (in_data.kind)
				sch_pkg::KIND_SPIKE: begin
					if (finalized_q) begin
						res_status_q <= sch_pkg::ST_FINALIZED;
					end else if (in_grp_bad) begin
						res_status_q <= sch_pkg::ST_BAD_GROUP;
					end
				end
				sch_pkg::KIND_READ: begin
					if (in_read_bad) begin
						res_status_q <= sch_pkg::ST_BAD_READ;
					end
				end
				default: ;
			endcase
		end
		// zero interval or zero bins give a zero bound: always out of range
		if (state_q == S_CHK && !div_start) begin
			res_status_q <= sch_pkg::ST_BAD_BIN;
		end
		if (state_q == S_RDAT) begin
			res_value_q <= rd_wide[31:0];
		end
		if (state_q == S_FIN) begin
			fin_first_s1 <= (fb_q == '0);
			fin_addr_s1  <= fin_rd_addr;
		end
		if (fin_v_s1) begin
			run_q <= fin_val;
		end
		if (state_q == S_OUT && out_free) begin
			out_q.status      <= res_status_q;
			out_q.count_value <= res_value_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	sch_div #(
		.QW(QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (time_q),
		.divisor  (bin_interval_q),
		.done     (div_done),
		.quotient (quotient)
	);

	sch_mem #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_mem (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// finalize stream never writes the entry it is reading
	a_fin_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && fin_v_s1) |-> (fin_addr_s1 != fin_rd_addr))
		else $error("finalize read and write hit the same entry");

	// a spike never updates the table once it is summed
	a_no_spike_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWR) |-> !finalized_q)
		else $error("spike written after finalize");

	// divider completes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside divide state");

	// a result held back by a full output register stays pending
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && out_valid_q && !out_ready) |=> (state_q == S_OUT))
		else $error("result dropped while output register full");

endmodule
